>>> design/circular_or_linear_mean_spread_core_assert.svh
// Assertion macros for the mean and spread core.
`ifndef CIRCULAR_OR_LINEAR_MEAN_SPREAD_CORE_ASSERT_SVH
`define CIRCULAR_OR_LINEAR_MEAN_SPREAD_CORE_ASSERT_SVH

// implication checked in the same cycle
`define CLMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define CLMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/clms_pkg.sv
// Types, constants and the arctangent table of the mean and spread core.
package clms_pkg;

    localparam int DEF_MAX_VALUES   = 1024;
    localparam int DEF_CORDIC_STEPS = 24;
    localparam int SHW              = 5;

    localparam logic signed [33:0] X_INIT = 34'sd652032874;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ZERO  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_OVF   = 2'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } clms_in_t;

    typedef struct packed {
        logic signed [31:0] mean;
        logic [31:0]        max_dev;
        logic [1:0]         status;
    } clms_out_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROT, ST_ACC, ST_FIN, ST_VEC, ST_DIV, ST_SWEEP, ST_OUT
    } clms_state_t;

    typedef struct packed {
        logic load;
        logic rot_step;
        logic rot_acc;
        logic vec_init;
        logic vec_step;
        logic div_init;
        logic div_step;
        logic sweep_rd;
        logic sweep_cmp;
        logic out_load;
    } clms_cmd_t;

    typedef struct packed {
        logic stored;
        logic last;
        logic periodic;
        logic busy;
    } clms_sts_t;

    function automatic logic [31:0] arc(input logic [SHW-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> design/circular_or_linear_mean_spread_core.sv
// Top level of the linear or circular mean and spread core.
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+---------------------------------
//  input    | s_valid s_ready s_word        | one value word, last flag
//  result   | m_valid m_ready m_word        | mean, max_dev, status
//  config   | cfg_wr_en cfg_wr_data         | periodic_mode bit, no wait
//
// Each stored word is accepted, rotated in the CORDIC loop and then
// accumulated; a dropped word is only accepted and flags overflow. After
// the last word the core runs CORDIC vectoring (periodic) or restoring
// division (linear), then sweeps the value store over its single read
// port. Reset is synchronous, active low, and needs no clearing pass:
// store entries are only read after they were written in the current set.
// A finished result waits in the output register; new words are taken
// meanwhile, and the next result holds until the register frees.
module circular_or_linear_mean_spread_core #(
    parameter int MAX_VALUES   = clms_pkg::DEF_MAX_VALUES,
    parameter int CORDIC_STEPS = clms_pkg::DEF_CORDIC_STEPS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  clms_pkg::clms_in_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output clms_pkg::clms_out_t m_word
);
    import clms_pkg::*;

    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int AW = $clog2(MAX_VALUES);

    clms_cmd_t      cmd;
    clms_sts_t      sts;
    logic [CW-1:0]  count;
    logic [SHW-1:0] step_idx;
    logic [AW-1:0]  sweep_addr;

    // sequencer: owns the handshake on the input side and all step counts
    clms_ctrl #(
        .MAX_VALUES(MAX_VALUES), .CORDIC_STEPS(CORDIC_STEPS), .CW(CW), .AW(AW)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_last(s_word.last), .s_ready(s_ready),
        .sts(sts), .count(count), .cmd(cmd),
        .step_idx(step_idx), .sweep_addr(sweep_addr)
    );

    // datapath: store, accumulators, CORDIC, divider, result register
    clms_dp #(
        .MAX_VALUES(MAX_VALUES), .CW(CW), .AW(AW)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_word(s_word), .m_word(m_word), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .step_idx(step_idx), .sweep_addr(sweep_addr),
        .sts(sts), .count(count)
    );

endmodule

>>> design/clms_ctrl.sv
// Sequencer of the mean and spread core.
module clms_ctrl #(
    parameter int MAX_VALUES   = clms_pkg::DEF_MAX_VALUES,
    parameter int CORDIC_STEPS = clms_pkg::DEF_CORDIC_STEPS,
    parameter int CW           = $clog2(MAX_VALUES + 1),
    parameter int AW           = $clog2(MAX_VALUES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_last,
    output logic                     s_ready,
    input  clms_pkg::clms_sts_t      sts,
    input  logic [CW-1:0]            count,
    output clms_pkg::clms_cmd_t      cmd,
    output logic [clms_pkg::SHW-1:0] step_idx,
    output logic [AW-1:0]            sweep_addr
);
    import clms_pkg::*;

    localparam int DIVB = 32 + CW + 1;
    localparam int KW   = $clog2(DIVB + 1);
    localparam logic [KW-1:0] ROT_END = KW'(CORDIC_STEPS - 1);
    localparam logic [KW-1:0] DIV_END = KW'(DIVB - 1);

    clms_state_t   state_reg, state_next;
    logic [KW-1:0] step_reg, step_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic          pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
        end
    end

    assign step_idx   = step_reg[SHW-1:0];
    assign sweep_addr = sweep_reg[AW-1:0];
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sweep_next = sweep_reg;
        pend_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load  = 1'b1;
                    step_next = '0;
                    if (sts.stored) state_next = ST_ROT;
                    else if (s_last) state_next = ST_FIN;
                end
            end
            ST_ROT: begin
                cmd.rot_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == ROT_END) begin
                    state_next = ST_ACC;
                    step_next  = '0;
                end
            end
            ST_ACC: begin
                cmd.rot_acc = 1'b1;
                state_next  = sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                step_next = '0;
                if (sts.periodic) begin
                    cmd.vec_init = 1'b1;
                    state_next   = ST_VEC;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_VEC: begin
                cmd.vec_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == ROT_END) begin
                    state_next = ST_SWEEP;
                    sweep_next = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_END) begin
                    state_next = ST_SWEEP;
                    sweep_next = '0;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_cmp = pend_reg;
                if (sweep_reg < count) begin
                    cmd.sweep_rd = 1'b1;
                    pend_next    = 1'b1;
                    sweep_next   = sweep_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!sts.busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`include "circular_or_linear_mean_spread_core_assert.svh"

    `CLMS_ASSERT_NOW(a_sweep_in_range, state_reg == ST_SWEEP, sweep_reg <= count, "sweep past count")
    `CLMS_ASSERT_NOW(a_out_free, cmd.out_load, !sts.busy, "result loaded over pending word")
    `CLMS_ASSERT_NEXT(a_cmp_follows_rd, cmd.sweep_rd, cmd.sweep_cmp, "read not compared")
    `CLMS_ASSERT_NEXT(a_load_leaves_idle, s_valid && s_ready && sts.stored, state_reg == ST_ROT, "stored word not rotated")

endmodule

>>> design/clms_dp.sv
// Datapath: value store, sums, CORDIC, divider, spread sweep and result register.
module clms_dp #(
    parameter int MAX_VALUES   = clms_pkg::DEF_MAX_VALUES,
    parameter int CW           = $clog2(MAX_VALUES + 1),
    parameter int AW           = $clog2(MAX_VALUES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  clms_pkg::clms_in_t       s_word,
    output clms_pkg::clms_out_t      m_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    input  clms_pkg::clms_cmd_t      cmd,
    input  logic [clms_pkg::SHW-1:0] step_idx,
    input  logic [AW-1:0]            sweep_addr,
    output clms_pkg::clms_sts_t      sts,
    output logic [CW-1:0]            count
);
    import clms_pkg::*;

    localparam int LW = 32 + CW;
    localparam int SW = 22 + CW;
    localparam int VW = SW + 24 + 2;
    localparam logic [CW-1:0] CMAX = CW'(MAX_VALUES);

    logic [31:0] mem [MAX_VALUES];
    logic [31:0] rd_reg;

    logic                 mode_reg, periodic_reg, last_reg, ovf_reg;
    logic [CW-1:0]        count_reg;
    logic signed [LW-1:0] lsum_reg;
    logic signed [SW-1:0] csum_reg, ssum_reg;
    logic signed [33:0]   rx_reg, ry_reg, rz_reg;
    logic                 flip_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic [31:0]          vz_reg;
    logic                 vzero_reg;
    logic [CW-1:0]        rem_reg;
    logic [LW:0]          quo_reg;
    logic                 neg_reg;
    logic [32:0]          dev_reg;
    logic                 m_valid_reg;
    clms_out_t            m_word_reg;

    logic                 stored;
    logic signed [33:0]   zin, rxr, ryr, arc_s;
    logic                 fl;
    logic signed [21:0]   cr, sr;
    logic signed [SW-1:0] cs_s, ss_s;
    logic signed [VW-1:0] vx0, vy0;
    logic [LW-1:0]        mag;
    logic [CW:0]          trial;
    logic                 ge;
    logic [33:0]          q34;
    logic signed [33:0]   mean_lin;
    logic [31:0]          dp;
    logic signed [33:0]   dl;
    logic [32:0]          ad;
    logic [1:0]           stat;

    assign stored = (count_reg < CMAX);
    assign count  = count_reg;
    assign sts    = '{stored: stored, last: last_reg, periodic: periodic_reg,
                      busy: m_valid_reg && !m_ready};
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // quarter-turn fold for the rotation
    always_comb begin
        fl  = ($signed(s_word.value) > 32'sh40000000) ||
              ($signed(s_word.value) < -32'sh40000000);
        zin = fl ? 34'($signed({~s_word.value[31], s_word.value[30:0]}))
                 : 34'($signed(s_word.value));
        arc_s = $signed({2'b00, arc(step_idx)});
        rxr = rx_reg + 34'sd2048;
        ryr = ry_reg + 34'sd2048;
        cr  = rxr[33:12];
        sr  = ryr[33:12];
        cs_s = flip_reg ? -SW'(cr) : SW'(cr);
        ss_s = flip_reg ? -SW'(sr) : SW'(sr);
        vx0 = VW'(csum_reg) <<< 24;
        vy0 = VW'(ssum_reg) <<< 24;
        mag = lsum_reg[LW-1] ? LW'(-lsum_reg) : LW'(lsum_reg);
        trial = {rem_reg, quo_reg[LW]};
        ge    = (trial >= {1'b0, count_reg});
        q34   = {2'b00, quo_reg[31:0]};
        mean_lin = neg_reg ? -$signed(q34) : $signed(q34);
        dp = rd_reg - vz_reg;
        dl = 34'($signed(rd_reg)) - mean_lin;
        if (periodic_reg) ad = {1'b0, dp[31] ? -dp : dp};
        else              ad = dl[33] ? 33'(-dl) : 33'(dl);
        if (count_reg == '0)    stat = STAT_EMPTY;
        else if (ovf_reg)       stat = STAT_OVF;
        else if (dev_reg == '0) stat = STAT_ZERO;
        else                    stat = STAT_OK;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && stored) mem[count_reg[AW-1:0]] <= s_word.value;
        if (cmd.sweep_rd) rd_reg <= mem[sweep_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            count_reg   <= '0;
            lsum_reg    <= '0;
            csum_reg    <= '0;
            ssum_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) mode_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.load) begin
                if (stored) begin
                    count_reg <= count_reg + 1'b1;
                    lsum_reg  <= lsum_reg + LW'(s_word.value);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.rot_acc) begin
                csum_reg <= csum_reg + cs_s;
                ssum_reg <= ssum_reg + ss_s;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                count_reg   <= '0;
                lsum_reg    <= '0;
                csum_reg    <= '0;
                ssum_reg    <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg <= s_word.last;
            if (s_word.last) periodic_reg <= mode_reg;
            rx_reg   <= X_INIT;
            ry_reg   <= '0;
            rz_reg   <= zin;
            flip_reg <= fl;
        end
        if (cmd.rot_step) begin
            if (!rz_reg[33]) begin
                rx_reg <= rx_reg - (ry_reg >>> step_idx);
                ry_reg <= ry_reg + (rx_reg >>> step_idx);
                rz_reg <= rz_reg - arc_s;
            end else begin
                rx_reg <= rx_reg + (ry_reg >>> step_idx);
                ry_reg <= ry_reg - (rx_reg >>> step_idx);
                rz_reg <= rz_reg + arc_s;
            end
        end
        if (cmd.vec_init) begin
            vzero_reg <= (csum_reg == '0) && (ssum_reg == '0);
            dev_reg   <= '0;
            if (csum_reg < 0) begin
                vx_reg <= -vx0;
                vy_reg <= -vy0;
                vz_reg <= 32'h80000000;
            end else begin
                vx_reg <= vx0;
                vy_reg <= vy0;
                vz_reg <= '0;
            end
        end
        if (cmd.vec_step && !vzero_reg) begin
            if (!vy_reg[VW-1]) begin
                vx_reg <= vx_reg + (vy_reg >>> step_idx);
                vy_reg <= vy_reg - (vx_reg >>> step_idx);
                vz_reg <= vz_reg + arc(step_idx);
            end else begin
                vx_reg <= vx_reg - (vy_reg >>> step_idx);
                vy_reg <= vy_reg + (vx_reg >>> step_idx);
                vz_reg <= vz_reg - arc(step_idx);
            end
        end
        if (cmd.div_init) begin
            dev_reg <= '0;
            neg_reg <= lsum_reg[LW-1];
            rem_reg <= '0;
            quo_reg <= {1'b0, mag} + (LW + 1)'(count_reg >> 1);
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? CW'(trial - {1'b0, count_reg}) : CW'(trial);
            quo_reg <= {quo_reg[LW-1:0], ge};
        end
        if (cmd.sweep_cmp && (ad > dev_reg)) dev_reg <= ad;
        if (cmd.out_load) begin
            m_word_reg.status <= stat;
            if (count_reg == '0) begin
                m_word_reg.mean    <= '0;
                m_word_reg.max_dev <= '0;
            end else begin
                m_word_reg.mean    <= periodic_reg ? $signed(vz_reg) : mean_lin[31:0];
                m_word_reg.max_dev <= dev_reg[31:0];
            end
        end
    end

endmodule
